@@ rtl/core/ksss_pkg.sv @@
// ----------------------------------------------------------------------------
// ksss_pkg
// Shared types and constants of the k-sorted stream sorter.
// ----------------------------------------------------------------------------
package ksss_pkg;

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned WIN_W      = 4;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_ADDR_W = 3;

  // Register index as taken from the word address bit.
  localparam logic REG_WINDOW_K = 1'b0;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_SWAP,
    OP_POP
  } ksss_op_t;

  typedef enum logic {
    ST_RUN,
    ST_DRAIN
  } ksss_state_t;

  // What one cell shows its neighbors.
  typedef struct packed {
    logic                     lt;
    logic signed [DATA_W-1:0] data;
  } ksss_link_t;

  // Broadcast to every cell of the row.
  typedef struct packed {
    ksss_op_t                 op;
    logic signed [DATA_W-1:0] value;
  } ksss_ctl_t;

endpackage

@@ rtl/core/ksss_cell.sv @@
// ----------------------------------------------------------------------------
// ksss_cell
// One slot of the sorted row: holds a value and takes the new value or its
// neighbor's value when the row shifts around an insertion or a removal.
// ----------------------------------------------------------------------------
module ksss_cell (
  input  logic                clk,
  input  ksss_pkg::ksss_ctl_t ctl,
  input  logic                head,
  input  logic                occ,
  input  ksss_pkg::ksss_link_t left_link,
  input  ksss_pkg::ksss_link_t right_link,
  output ksss_pkg::ksss_link_t link
);

  logic signed [ksss_pkg::DATA_W-1:0] data_r;
  logic signed [ksss_pkg::DATA_W-1:0] data_nxt;
  logic                               lt;

  assign lt        = occ && (data_r < ctl.value);
  assign link.lt   = lt;
  assign link.data = data_r;

  always_comb begin
    unique case (ctl.op)
      ksss_pkg::OP_HOLD: begin
        data_nxt = data_r;
      end
      ksss_pkg::OP_INSERT: begin
        if (lt) begin
          data_nxt = data_r;
        end else if (head || left_link.lt) begin
          data_nxt = ctl.value;
        end else begin
          data_nxt = left_link.data;
        end
      end
      ksss_pkg::OP_SWAP: begin
        if (right_link.lt) begin
          data_nxt = right_link.data;
        end else if (head || lt) begin
          data_nxt = ctl.value;
        end else begin
          data_nxt = data_r;
        end
      end
      ksss_pkg::OP_POP: begin
        data_nxt = right_link.data;
      end
      default: begin
        data_nxt = data_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

@@ rtl/core/k_sorted_stream_sorter.sv @@
// ----------------------------------------------------------------------------
// k_sorted_stream_sorter
// Sorts a stream whose words lie at most window_k places from their order.
// ----------------------------------------------------------------------------
// The input channel carries one signed value per word, with in_tlast on the
// final word of a sequence. The output channel returns the values in
// ascending order, with out_tlast on the final word of the sequence.
// Register window_k sits at byte address 0 of the APB-style port; values
// above MAX_WINDOW act as MAX_WINDOW. Write it only while the block is idle.
// Values are held in a row of MAX_WINDOW + 1 cells kept in ascending order.
// Once window_k + 1 values are held, each input word pushes out the smallest
// one, which appears on the output in the cycle after the input is accepted.
// One input word is taken per cycle while the output register can move.
// After a word marked last, the row drains one word per cycle while the output
// register can move; the input is held off until all (up to MAX_WINDOW + 1) held
// values are out. Reset empties the row and clears window_k. A stalled receiver
// holds the output word and, through it, the input channel.
// ----------------------------------------------------------------------------
module k_sorted_stream_sorter #(
  parameter int unsigned MAX_WINDOW = 15
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [ksss_pkg::DATA_W-1:0]         in_tdata,   // [31:0] value
  input  logic                                in_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [ksss_pkg::DATA_W-1:0]         out_tdata,  // [31:0] sorted_value
  output logic                                out_tlast,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [ksss_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [ksss_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [ksss_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);

  localparam int unsigned DEPTH = MAX_WINDOW + 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = CNT_W + ksss_pkg::WIN_W;

  logic [ksss_pkg::WIN_W-1:0]  window_k_r;
  logic                        reg_sel;
  logic                        cfg_wr;
  logic [CMP_W-1:0]            k_wide;
  logic [CMP_W-1:0]            k_clamp;
  logic [CNT_W-1:0]            cap;
  logic [CNT_W-1:0]            count_r;
  logic [CNT_W-1:0]            count_nxt;
  ksss_pkg::ksss_state_t       state_r;
  ksss_pkg::ksss_state_t       state_nxt;
  logic                        out_valid_r;
  logic                        out_valid_nxt;
  logic [ksss_pkg::DATA_W-1:0] out_data_r;
  logic                        out_last_r;
  logic                        out_last_nxt;
  logic                        out_free;
  logic                        accept;
  logic                        full;
  logic                        emit;
  ksss_pkg::ksss_ctl_t         ctl;
  ksss_pkg::ksss_link_t        links [DEPTH];
  ksss_pkg::ksss_link_t        edge_link;

  // Configuration port.
  assign cfg_pready = 1'b1;
  assign reg_sel    = (cfg_paddr[2] == ksss_pkg::REG_WINDOW_K);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = reg_sel
                    ? {{(ksss_pkg::CFG_DATA_W - ksss_pkg::WIN_W){1'b0}}, window_k_r}
                    : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_k_r <= '0;
    end else if (cfg_wr && reg_sel) begin
      window_k_r <= cfg_pwdata[ksss_pkg::WIN_W-1:0];
    end
  end

  assign k_wide  = CMP_W'(window_k_r);
  assign k_clamp = (k_wide > CMP_W'(MAX_WINDOW)) ? CMP_W'(MAX_WINDOW) : k_wide;
  assign cap     = k_clamp[CNT_W-1:0] + CNT_W'(1);

  // Handshake and row control.
  assign out_free = !out_valid_r || out_tready;
  assign full     = (count_r >= cap);
  assign accept   = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ksss_pkg::ST_RUN: begin
        if (accept && in_tlast) begin
          state_nxt = ksss_pkg::ST_DRAIN;
        end
      end
      ksss_pkg::ST_DRAIN: begin
        if (out_free && (count_r == CNT_W'(1))) begin
          state_nxt = ksss_pkg::ST_RUN;
        end
      end
      default: begin
        state_nxt = ksss_pkg::ST_RUN;
      end
    endcase
  end

  always_comb begin
    in_tready    = 1'b0;
    ctl.op       = ksss_pkg::OP_HOLD;
    ctl.value    = $signed(in_tdata);
    emit         = 1'b0;
    out_last_nxt = 1'b0;
    unique case (state_r)
      ksss_pkg::ST_RUN: begin
        in_tready = out_free;
        if (in_tvalid && out_free) begin
          ctl.op = full ? ksss_pkg::OP_SWAP : ksss_pkg::OP_INSERT;
          emit   = full;
        end
      end
      ksss_pkg::ST_DRAIN: begin
        if (out_free) begin
          ctl.op       = ksss_pkg::OP_POP;
          emit         = 1'b1;
          out_last_nxt = (count_r == CNT_W'(1));
        end
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  always_comb begin
    unique case (ctl.op)
      ksss_pkg::OP_INSERT: count_nxt = count_r + CNT_W'(1);
      ksss_pkg::OP_POP:    count_nxt = count_r - CNT_W'(1);
      default:             count_nxt = count_r;
    endcase
  end

  assign out_valid_nxt = emit ? 1'b1 : (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ksss_pkg::ST_RUN;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (emit) begin
        out_last_r <= out_last_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= links[0].data;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // Sorted row of cells, smallest value in cell 0.
  assign edge_link.lt   = 1'b0;
  assign edge_link.data = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    ksss_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .head       (i == 0),
      .occ        (count_r > CNT_W'(i)),
      .left_link  ((i == 0) ? edge_link : links[(i == 0) ? 0 : i - 1]),
      .right_link ((i == DEPTH - 1) ? edge_link : links[(i == DEPTH - 1) ? i : i + 1]),
      .link       (links[i])
    );
  end

`ifndef NO_ASSERTIONS
  logic row_unsorted;

  always_comb begin
    row_unsorted = 1'b0;
    for (int i = 0; i < DEPTH - 1; i++) begin
      if ((count_r > CNT_W'(i + 1)) && (links[i + 1].data < links[i].data)) begin
        row_unsorted = 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("Held count exceeds the row depth.");

  a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ksss_pkg::ST_DRAIN |-> count_r != '0)
    else $error("Drain running on an empty row.");

  a_last_empties: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> count_r == '0 && state_r == ksss_pkg::ST_RUN)
    else $error("Final word shown while values remain held.");

  a_row_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    !row_unsorted)
    else $error("Occupied cells are out of ascending order.");
`endif

endmodule
